@@ rtl/char_lcd_stream_cursor_assert.svh @@
// Assertion macros used by the port-level checker clsc_checker.
// Depends on nothing; include by bare file name.
`ifndef CHAR_LCD_STREAM_CURSOR_ASSERT_SVH
`define CHAR_LCD_STREAM_CURSOR_ASSERT_SVH

// Same-cycle implication.
`define CLSC_ASSERT_NOW(lbl, clk, dis, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
      else $error("clsc: assertion failed");

// Next-cycle implication.
`define CLSC_ASSERT_NEXT(lbl, clk, dis, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
      else $error("clsc: assertion failed");

`endif

@@ rtl/clsc_pkg.sv @@
// Package for the character LCD stream cursor block: codes, tables, job type.
// No dependencies.
`timescale 1ns / 1ps

package clsc_pkg;

   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_NL    = 8'h0A;
   localparam logic [7:0] CHAR_VT    = 8'h0B;
   localparam logic [7:0] CHAR_FF    = 8'h0C;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   localparam logic [5:0] MAX_WIDTH = 6'd40;
   localparam logic [2:0] MAX_ROWS  = 3'd4;

   localparam logic [5:0] RESET_WIDTH = 6'd16;
   localparam logic [2:0] RESET_ROWS  = 3'd2;

   localparam logic CSR_ROW_WIDTH = 1'b0;
   localparam logic CSR_ROW_COUNT = 1'b1;

   localparam logic CMD_WRITE_CHAR = 1'b0;
   localparam logic CMD_SET_ADDR   = 1'b1;

   localparam logic [6:0] ROW_BASE [4] = '{7'h00, 7'h40, 7'h14, 7'h54};

   typedef struct packed {
      logic       lead_en;
      logic [6:0] lead_addr;
      logic [6:0] pad_cnt;
      logic       char_en;
      logic [7:0] char_val;
      logic       tail_en;
      logic [6:0] tail_addr;
   } job_type;

endpackage

@@ rtl/clsc_front.sv @@
// Front end: config registers, cursor state, per-byte job classification.
// Depends on clsc_pkg.
`timescale 1ns / 1ps

module clsc_front import clsc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [5:0] csr_wdata,
   input  logic       take,
   input  logic [7:0] char_in,
   output job_type    job
);

   logic [5:0] width_ff, width_in;
   logic [2:0] rows_ff, rows_in;
   logic [6:0] addr_ff, addr_in;
   logic [1:0] row_ff, row_in;
   logic       wrapped_ff, wrapped_in;

   logic [5:0] eff_width;
   logic [2:0] eff_rows;
   logic [6:0] start;
   logic [7:0] limit;
   logic [6:0] addr_inc;
   logic [1:0] row_next;

   function automatic logic [1:0] next_row(input logic [1:0] row, input logic [2:0] rows);
      logic [2:0] v;
      logic [1:0] r;
      v = {1'b0, row} + 3'd1;
      case (rows)
         3'd1:    r = 2'd0;
         3'd2:    r = {1'b0, v[0]};
         3'd3:    r = (v == 3'd3) ? 2'd0 : ((v == 3'd4) ? 2'd1 : v[1:0]);
         default: r = v[1:0];
      endcase
      return r;
   endfunction

   always_comb begin
      if (width_ff == 6'd0) begin
         eff_width = 6'd1;
      end else if (width_ff > MAX_WIDTH) begin
         eff_width = MAX_WIDTH;
      end else begin
         eff_width = width_ff;
      end
      if (rows_ff == 3'd0) begin
         eff_rows = 3'd1;
      end else if (rows_ff > MAX_ROWS) begin
         eff_rows = MAX_ROWS;
      end else begin
         eff_rows = rows_ff;
      end
   end

   assign start    = ROW_BASE[row_ff];
   assign limit    = {1'b0, start} + {2'b00, eff_width};
   assign addr_inc = addr_ff + 7'd1;
   assign row_next = next_row(row_ff, eff_rows);

   always_comb begin
      width_in   = width_ff;
      rows_in    = rows_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ROW_WIDTH: width_in = csr_wdata;
            CSR_ROW_COUNT: rows_in  = csr_wdata[2:0];
            default:       width_in = width_ff;
         endcase
      end

      addr_in    = addr_ff;
      row_in     = row_ff;
      wrapped_in = wrapped_ff;

      job.lead_en   = (addr_ff == start);
      job.lead_addr = addr_ff;
      job.pad_cnt   = 7'd0;
      job.char_en   = 1'b0;
      job.char_val  = char_in;
      job.tail_en   = 1'b0;
      job.tail_addr = addr_ff;

      case (char_in) inside
         CHAR_NL, CHAR_VT, CHAR_CR: begin
            if ((char_in == CHAR_NL) && !wrapped_ff && ({1'b0, addr_ff} < limit)) begin
               job.pad_cnt = 7'(limit - {1'b0, addr_ff});
            end
            if ((char_in != CHAR_CR) && !wrapped_ff) begin
               row_in  = row_next;
               addr_in = ROW_BASE[row_next];
            end else begin
               addr_in = start;
            end
            wrapped_in = 1'b0;
         end
         CHAR_FF: begin
            row_in     = 2'd0;
            addr_in    = ROW_BASE[0];
            wrapped_in = 1'b0;
         end
         default: begin
            job.char_en = (char_in != CHAR_TAB);
            if ({1'b0, addr_inc} >= limit) begin
               wrapped_in  = 1'b1;
               row_in      = row_next;
               addr_in     = ROW_BASE[row_next];
               job.tail_en = 1'b1;
            end else begin
               wrapped_in  = 1'b0;
               addr_in     = addr_inc;
               job.tail_en = (char_in == CHAR_TAB);
            end
            job.tail_addr = addr_in;
         end
      endcase

      if (!take) begin
         addr_in    = addr_ff;
         row_in     = row_ff;
         wrapped_in = wrapped_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= RESET_WIDTH;
         rows_ff    <= RESET_ROWS;
         addr_ff    <= 7'd0;
         row_ff     <= 2'd0;
         wrapped_ff <= 1'b0;
      end else begin
         width_ff   <= width_in;
         rows_ff    <= rows_in;
         addr_ff    <= addr_in;
         row_ff     <= row_in;
         wrapped_ff <= wrapped_in;
      end
   end

endmodule

@@ rtl/clsc_queue.sv @@
// Job queue between the front end and the command sequencer.
// Depends on clsc_pkg.
`timescale 1ns / 1ps

module clsc_queue import clsc_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type wr_data,
   input  logic    pop,
   output logic    full,
   output logic    empty,
   output job_type rd_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ rtl/clsc_back.sv @@
// Command sequencer: expands one job into LCD commands, written to the result
// register one per cycle unless it is full and not popped. Depends on clsc_pkg.
`timescale 1ns / 1ps

module clsc_back import clsc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_empty,
   input  job_type    q_data,
   output logic       q_pop,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic       rsp_cmd_kind,
   output logic [7:0] rsp_cmd_value,
   output logic       rsp_run_last
);

   logic       lead_ff, lead_in;
   logic [6:0] lead_addr_ff, lead_addr_in;
   logic [6:0] pad_ff, pad_in;
   logic       char_ff, char_in;
   logic [7:0] char_val_ff, char_val_in;
   logic       tail_ff, tail_in;
   logic [6:0] tail_addr_ff, tail_addr_in;

   logic       valid_ff, valid_in;
   logic       kind_ff, kind_in;
   logic [7:0] value_ff, value_in;
   logic       last_ff, last_in;

   logic busy, can_emit, emit;

   assign busy     = lead_ff || (pad_ff != 7'd0) || char_ff || tail_ff;
   assign can_emit = !valid_ff || rsp_pop;

   always_comb begin
      lead_in      = lead_ff;
      lead_addr_in = lead_addr_ff;
      pad_in       = pad_ff;
      char_in      = char_ff;
      char_val_in  = char_val_ff;
      tail_in      = tail_ff;
      tail_addr_in = tail_addr_ff;
      q_pop        = 1'b0;
      emit         = 1'b0;
      kind_in      = kind_ff;
      value_in     = value_ff;
      last_in      = last_ff;

      if (busy) begin
         if (can_emit) begin
            emit = 1'b1;
            if (lead_ff) begin
               kind_in  = CMD_SET_ADDR;
               value_in = {1'b0, lead_addr_ff};
               last_in  = !((pad_ff != 7'd0) || char_ff || tail_ff);
               lead_in  = 1'b0;
            end else if (pad_ff != 7'd0) begin
               kind_in  = CMD_WRITE_CHAR;
               value_in = CHAR_SPACE;
               last_in  = (pad_ff == 7'd1) && !char_ff && !tail_ff;
               pad_in   = pad_ff - 7'd1;
            end else if (char_ff) begin
               kind_in  = CMD_WRITE_CHAR;
               value_in = char_val_ff;
               last_in  = !tail_ff;
               char_in  = 1'b0;
            end else begin
               kind_in  = CMD_SET_ADDR;
               value_in = {1'b0, tail_addr_ff};
               last_in  = 1'b1;
               tail_in  = 1'b0;
            end
         end
      end else if (!q_empty) begin
         q_pop        = 1'b1;
         lead_in      = q_data.lead_en;
         lead_addr_in = q_data.lead_addr;
         pad_in       = q_data.pad_cnt;
         char_in      = q_data.char_en;
         char_val_in  = q_data.char_val;
         tail_in      = q_data.tail_en;
         tail_addr_in = q_data.tail_addr;
      end

      if (emit) begin
         valid_in = 1'b1;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_ff  <= 1'b0;
         pad_ff   <= 7'd0;
         char_ff  <= 1'b0;
         tail_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         lead_ff  <= lead_in;
         pad_ff   <= pad_in;
         char_ff  <= char_in;
         tail_ff  <= tail_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lead_addr_ff <= lead_addr_in;
      char_val_ff  <= char_val_in;
      tail_addr_ff <= tail_addr_in;
      kind_ff      <= kind_in;
      value_ff     <= value_in;
      last_ff      <= last_in;
   end

   assign rsp_empty     = !valid_ff;
   assign rsp_cmd_kind  = kind_ff;
   assign rsp_cmd_value = value_ff;
   assign rsp_run_last  = last_ff;

endmodule

@@ rtl/char_lcd_stream_cursor.sv @@
// Top level of the character LCD stream cursor block.
// Depends on clsc_pkg, clsc_front, clsc_queue, clsc_back.
//
//   channel   ports                                  accepted when
//   input     req_push req_full req_char_in          req_push && !req_full
//   result    rsp_empty rsp_pop rsp_cmd_*            rsp_pop && !rsp_empty
//   config    csr_we csr_index csr_wdata             csr_we
//
// The front end takes one byte per cycle while the job queue has room.
// The sequencer emits one command per cycle unless the result register is
// held; it loads each byte's job from the queue, then emits its commands.
// A byte that causes no command is still loaded by the sequencer.
// Synchronous reset clears cursor state, queue and result register.
// A held rsp_pop stall fills the queue and then raises req_full.
`timescale 1ns / 1ps

module char_lcd_stream_cursor import clsc_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_char_in,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic       rsp_cmd_kind,
   output logic [7:0] rsp_cmd_value,
   output logic       rsp_run_last,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [5:0] csr_wdata
);

   job_type front_job;
   job_type q_data;
   logic    take;
   logic    q_empty;
   logic    q_pop;

   assign take = req_push && !req_full;

   clsc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .take      (take),
      .char_in   (req_char_in),
      .job       (front_job)
   );

   clsc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (take),
      .wr_data (front_job),
      .pop     (q_pop),
      .full    (req_full),
      .empty   (q_empty),
      .rd_data (q_data)
   );

   clsc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_data        (q_data),
      .q_pop         (q_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_cmd_kind  (rsp_cmd_kind),
      .rsp_cmd_value (rsp_cmd_value),
      .rsp_run_last  (rsp_run_last)
   );

endmodule

@@ rtl/clsc_checker.sv @@
// Port-level checker for char_lcd_stream_cursor, bound to the top level.
// Depends on clsc_pkg and char_lcd_stream_cursor_assert.svh.
`timescale 1ns / 1ps
`include "char_lcd_stream_cursor_assert.svh"

module clsc_checker import clsc_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_full,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic       rsp_cmd_kind,
   input logic [7:0] rsp_cmd_value,
   input logic       rsp_run_last
);

   logic       rsp_held;
   logic       rsp_is_addr;
   logic       rsp_is_write;
   logic       rsp_ctrl;
   logic [9:0] rsp_word;

   assign rsp_held     = !rsp_empty && !rsp_pop;
   assign rsp_is_addr  = !rsp_empty && (rsp_cmd_kind == CMD_SET_ADDR);
   assign rsp_is_write = !rsp_empty && (rsp_cmd_kind == CMD_WRITE_CHAR);
   assign rsp_ctrl     = rsp_cmd_value inside {CHAR_TAB, CHAR_NL, CHAR_VT, CHAR_FF, CHAR_CR};
   assign rsp_word     = {rsp_cmd_kind, rsp_cmd_value, rsp_run_last};

   `CLSC_ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset, rsp_empty && !req_full)

   `CLSC_ASSERT_NEXT(a_result_holds, clock, reset, rsp_held, !rsp_empty && $stable(rsp_word))

   `CLSC_ASSERT_NOW(a_addr_range, clock, reset, rsp_is_addr, !rsp_cmd_value[7])

   `CLSC_ASSERT_NOW(a_no_ctrl_write, clock, reset, rsp_is_write, !rsp_ctrl)

endmodule

bind char_lcd_stream_cursor clsc_checker u_clsc_checker (.*);

@@ sim/lcd_cmd_checker.sv @@
// Checker for the character LCD stream cursor: watches the byte, command and
// register ports, predicts the display commands and compares them in order.
// Depends on clsc_pkg.
`timescale 1ns / 1ps

module lcd_cmd_checker import clsc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic       req_full,
   input  logic [7:0] req_char_in,
   input  logic       rsp_empty,
   input  logic       rsp_pop,
   input  logic       rsp_cmd_kind,
   input  logic [7:0] rsp_cmd_value,
   input  logic       rsp_run_last,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [5:0] csr_wdata,
   output int         fail_count,
   output int         pending
);

   typedef struct packed {
      logic       kind;
      logic [7:0] value;
      logic       last;
   } lcd_cmd_type;

   lcd_cmd_type cmd_queue [$];
   logic [5:0]  width_reg;
   logic [2:0]  rows_reg;
   logic [6:0]  cur_addr;
   logic [1:0]  cur_row;
   logic        wrapped;

   function automatic lcd_cmd_type make_cmd(input logic kind, input int value);
      lcd_cmd_type cmd;
      cmd.kind  = kind;
      cmd.value = 8'(value);
      cmd.last  = 1'b0;
      return cmd;
   endfunction

   function automatic logic [1:0] next_row();
      int rows;
      rows = (rows_reg == 3'd0) ? 1 : (rows_reg > MAX_ROWS) ? int'(MAX_ROWS) : int'(rows_reg);
      return 2'((int'(cur_row) + 1) % rows);
   endfunction

   function automatic void predict_cmds(input logic [7:0] c);
      lcd_cmd_type run_cmds [$];
      lcd_cmd_type last_cmd;
      int          width;
      int          start;
      int          addr;
      width = (width_reg == 6'd0) ? 1 :
              (width_reg > MAX_WIDTH) ? int'(MAX_WIDTH) : int'(width_reg);
      start = int'(ROW_BASE[cur_row]);
      addr  = int'(cur_addr);
      if (addr == start) run_cmds.push_back(make_cmd(CMD_SET_ADDR, addr));
      if (c == CHAR_NL || c == CHAR_VT || c == CHAR_CR) begin
         if (c == CHAR_NL && !wrapped) begin
            while (addr < start + width) begin
               run_cmds.push_back(make_cmd(CMD_WRITE_CHAR, int'(CHAR_SPACE)));
               addr++;
            end
         end
         if (c != CHAR_CR && !wrapped) begin
            cur_row = next_row();
            start   = int'(ROW_BASE[cur_row]);
         end
         addr    = start;
         wrapped = 1'b0;
      end else if (c == CHAR_FF) begin
         cur_row = 2'd0;
         addr    = int'(ROW_BASE[0]);
         wrapped = 1'b0;
      end else begin
         if (c != CHAR_TAB) run_cmds.push_back(make_cmd(CMD_WRITE_CHAR, int'(c)));
         addr = (addr + 1) % 128;
         if (addr >= start + width) begin
            wrapped = 1'b1;
            cur_row = next_row();
            addr    = int'(ROW_BASE[cur_row]);
            if (c != CHAR_TAB) run_cmds.push_back(make_cmd(CMD_SET_ADDR, addr));
         end else begin
            wrapped = 1'b0;
         end
         if (c == CHAR_TAB) run_cmds.push_back(make_cmd(CMD_SET_ADDR, addr));
      end
      cur_addr = 7'(addr);
      if (run_cmds.size() > 0) begin
         last_cmd      = run_cmds.pop_back();
         last_cmd.last = 1'b1;
         run_cmds.push_back(last_cmd);
      end
      foreach (run_cmds[i]) cmd_queue.push_back(run_cmds[i]);
   endfunction

   always @(posedge clock) begin
      lcd_cmd_type exp_cmd;
      if (reset) begin
         cmd_queue.delete();
         width_reg  = RESET_WIDTH;
         rows_reg   = RESET_ROWS;
         cur_addr   = 7'd0;
         cur_row    = 2'd0;
         wrapped    = 1'b0;
         fail_count = 0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_ROW_WIDTH) width_reg = csr_wdata;
            else rows_reg = csr_wdata[2:0];
         end
         if (req_push && !req_full) predict_cmds(req_char_in);
         if (rsp_pop && !rsp_empty) begin
            if (cmd_queue.size() == 0) begin
               $error("unexpected command: kind %0d value 0x%02h run_last %0d",
                      rsp_cmd_kind, rsp_cmd_value, rsp_run_last);
               fail_count++;
            end else begin
               exp_cmd = cmd_queue.pop_front();
               if (rsp_cmd_kind !== exp_cmd.kind) begin
                  $error("cmd_kind expected %0d actual %0d", exp_cmd.kind, rsp_cmd_kind);
                  fail_count++;
               end
               if (rsp_cmd_value !== exp_cmd.value) begin
                  $error("cmd_value expected 0x%02h actual 0x%02h",
                         exp_cmd.value, rsp_cmd_value);
                  fail_count++;
               end
               if (rsp_run_last !== exp_cmd.last) begin
                  $error("run_last expected %0d actual %0d", exp_cmd.last, rsp_run_last);
                  fail_count++;
               end
            end
         end
      end
      pending = cmd_queue.size();
   end

endmodule

@@ sim/testbench.sv @@
// Top of the character LCD stream cursor test: clock, reset, byte stream,
// register writes and command pops with random gaps, and the verdict.
// Depends on clsc_pkg, char_lcd_stream_cursor and lcd_cmd_checker.
`timescale 1ns / 1ps

module testbench;
   import clsc_pkg::*;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_push    = 1'b0;
   logic       req_full;
   logic [7:0] req_char_in = 8'd0;
   logic       rsp_empty;
   logic       rsp_pop     = 1'b0;
   logic       rsp_cmd_kind;
   logic [7:0] rsp_cmd_value;
   logic       rsp_run_last;
   logic       csr_we      = 1'b0;
   logic       csr_index   = CSR_ROW_WIDTH;
   logic [5:0] csr_wdata   = 6'd0;
   int         fail_count;
   int         pending;
   bit         tx_steady   = 1'b0;
   bit         rx_steady   = 1'b0;
   bit         rx_hold_req = 1'b0;

   always #2 clock = ~clock;

   char_lcd_stream_cursor i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_char_in   (req_char_in),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_cmd_kind  (rsp_cmd_kind),
      .rsp_cmd_value (rsp_cmd_value),
      .rsp_run_last  (rsp_run_last),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   lcd_cmd_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_char_in   (req_char_in),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_cmd_kind  (rsp_cmd_kind),
      .rsp_cmd_value (rsp_cmd_value),
      .rsp_run_last  (rsp_run_last),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending       (pending)
   );

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [7:0] text_byte();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 8'($urandom_range(8'h20, 8'h7E));
      if (r < 85) begin
         case ($urandom_range(0, 4))
            0: return CHAR_TAB;
            1: return CHAR_VT;
            2: return CHAR_FF;
            3: return CHAR_CR;
            default: return CHAR_NL;
         endcase
      end
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic push_byte(input logic [7:0] b);
      int gap;
      req_push    <= 1'b1;
      req_char_in <= b;
      do @(posedge clock); while (req_full);
      @(negedge clock);
      gap = tx_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // hold until every command is out, then let trailing no-command bytes settle
   task automatic drain_cmds();
      req_push <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [5:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic set_geometry(input logic [5:0] w, input logic [2:0] r);
      drain_cmds();
      write_reg(CSR_ROW_WIDTH, w);
      write_reg(CSR_ROW_COUNT, {3'd0, r});
   endtask

   task automatic run_text(input int n, input logic [5:0] w, input logic [2:0] r);
      set_geometry(w, r);
      repeat (n) push_byte(text_byte());
   endtask

   // receiver: random pop gaps, plus one long hold on request
   initial begin
      int idle_left;
      idle_left = 0;
      forever begin
         @(negedge clock);
         if (rx_hold_req) begin
            idle_left   = 500;
            rx_hold_req = 1'b0;
         end
         if (idle_left > 0) begin
            rsp_pop <= 1'b0;
            idle_left--;
         end else begin
            rsp_pop <= 1'b1;
            if (!rx_steady) idle_left = pick_gap();
         end
      end
   end

   initial begin
      #8ms;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      push_byte(8'h00);
      push_byte(8'hFF);
      push_byte(8'h7F);
      push_byte(CHAR_TAB);
      push_byte(CHAR_CR);
      push_byte(CHAR_NL);
      push_byte(CHAR_VT);
      push_byte(CHAR_FF);

      // zero width and oversized row count
      set_geometry(6'd0, 3'd7);
      push_byte("a");
      push_byte(CHAR_NL);
      push_byte(CHAR_TAB);
      push_byte(CHAR_NL);
      push_byte("b");

      // oversized width, zero row count: full padding
      set_geometry(6'd63, 3'd0);
      push_byte(CHAR_NL);
      push_byte("z");
      push_byte(CHAR_NL);

      // park on the last row, then shrink width and row count
      set_geometry(6'd10, 3'd4);
      push_byte(CHAR_FF);
      push_byte(CHAR_VT);
      push_byte(CHAR_VT);
      push_byte(CHAR_VT);
      push_byte("q");
      push_byte("q");
      set_geometry(6'd2, 3'd2);
      push_byte(CHAR_NL);
      push_byte("r");

      set_geometry(6'd5, 3'd4);
      push_byte("q");
      push_byte("q");
      set_geometry(6'd1, 3'd4);
      push_byte("r");

      run_text(32, 6'd40, 3'd4);

      set_geometry(6'd1, 3'd1);
      rx_hold_req = 1'b1;
      repeat (24) push_byte(text_byte());

      run_text(16, 6'($urandom_range(0, 63)), 3'($urandom_range(0, 7)));
      req_push <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (16) push_byte(text_byte());

      drain_cmds();
      tx_steady = 1'b1;
      rx_steady = 1'b1;
      run_text(40, 6'($urandom_range(1, 40)), 3'($urandom_range(1, 4)));
      drain_cmds();
      tx_steady = 1'b0;
      rx_steady = 1'b0;

      run_text(8, 6'($urandom_range(0, 63)), 3'($urandom_range(0, 7)));

      drain_cmds();
      repeat (50) @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
